// ===== hw/rtl/ccp_pkg.sv =====
package ccp_pkg;

    // default configuration
    localparam int CCP_ITERATIONS   = 16;
    localparam int CCP_DATA_WIDTH   = 16;
    localparam int CCP_MAX_ITER     = 16;

    // q3.x format: integer bits above the fraction
    localparam int CCP_INT_BITS     = 3;

    // headroom of the x/y datapath over the input width
    localparam int CCP_GUARD_BITS   = 3;

    // 1/1.64676025786545 as a q0.30 constant
    localparam int CCP_GAIN_SHIFT   = 30;
    localparam logic [CCP_GAIN_SHIFT-1:0] CCP_INV_GAIN = 30'd652032874;

    // pipeline stages besides the micro-rotations: pre-rotation, multiply, output
    localparam int CCP_FIXED_STAGES = 3;

    localparam real CCP_HALF_PI = 1.5707963267948966;

    // atan(2^-idx) in radians
    function automatic real atan_real(input int idx);
        real v;
        unique case (idx)
            0:       v = 0.785398163397448309616;
            1:       v = 0.463647609000806116214;
            2:       v = 0.244978663126864154172;
            3:       v = 0.124354994546761435031;
            4:       v = 0.062418809995957348474;
            5:       v = 0.031239833430268276254;
            6:       v = 0.015623728620476830803;
            7:       v = 0.007812341060101111296;
            8:       v = 0.003906230131966971828;
            9:       v = 0.001953122516478818685;
            10:      v = 0.000976562189559319430;
            11:      v = 0.000488281211194898;
            12:      v = 0.000244140620149361;
            13:      v = 0.000122070311893670;
            14:      v = 0.0000610351561742087;
            15:      v = 0.0000305175781155261;
            default: v = 0.0;
        endcase
        return v;
    endfunction

    // positive real rounded to nearest at frac_bits fraction bits
    function automatic int to_fixed(input real v, input int frac_bits);
        return $rtoi(v * (2.0 ** frac_bits) + 0.5);
    endfunction

endpackage

// ===== hw/rtl/cordic_cartesian_to_polar.sv =====
// cartesian to polar converter, cordic vectoring mode
//
// command channel: present i_coord_x / i_coord_y with start high; the item is
// taken at the rising edge where start is high and busy is low. busy is only
// high while i_rst_n is low, so outside reset an item can be taken every cycle.
//
// result channel: o_valid marks the single cycle in which o_radius and o_angle
// hold the result; the receiver takes it at the edge that ends that cycle and
// cannot hold it off. results leave in the order the items came in.
//
// an item passes from the accepting edge through the pre-rotation register, one
// register per micro-rotation, the gain multiplier, then rounding and saturation,
// into the o_valid cycle. throughput is one item per clock outside reset, set by
// the fully unrolled micro-rotation pipeline.
//
// synchronous reset clears every valid bit, so items still in flight are
// dropped and o_valid stays low until new items come out. all values are
// signed q3.(DATA_WIDTH-3); radius and angle saturate to the format range.
module cordic_cartesian_to_polar
    import ccp_pkg::*;
#(
    parameter int ITERATIONS = CCP_ITERATIONS,
    parameter int DATA_WIDTH = CCP_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_coord_x,
    input  logic signed [DATA_WIDTH-1:0] i_coord_y,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_radius,
    output logic signed [DATA_WIDTH-1:0] o_angle
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = DW - CCP_INT_BITS;
    // x/y width: cordic gain times sqrt(2) stays below 4x the input range
    localparam int IW = DW + CCP_GUARD_BITS;
    // angle accumulator: one bit more than the output, sum stays below pi+0.2
    localparam int AW = DW + 1;
    // final x is never negative and below 2^(DW+1)
    localparam int MW = DW + 1;
    localparam int PW = MW + CCP_GAIN_SHIFT;
    localparam int RW = PW + 1 - CCP_GAIN_SHIFT;

    localparam logic signed [AW-1:0] HALF_PI = AW'(to_fixed(CCP_HALF_PI, FB));
    localparam logic [PW:0]   ROUND_HALF = (PW+1)'(1) << (CCP_GAIN_SHIFT - 1);
    localparam logic [RW-1:0] RAD_MAX    = (RW)'({(DW-1){1'b1}});
    localparam logic signed [DW-1:0] ANG_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] ANG_MIN = {1'b1, {(DW-1){1'b0}}};

    logic accept;

    // reset blocks new items; otherwise the pipeline never stalls
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // ---------------- stage 0: quadrant pre-rotation ----------------
    logic                 r_v0;
    logic signed [IW-1:0] r_x0, n_x0;
    logic signed [IW-1:0] r_y0, n_y0;
    logic signed [AW-1:0] r_z0, n_z0;
    logic signed [IW-1:0] ext_x, ext_y;

    assign ext_x = {{CCP_GUARD_BITS{i_coord_x[DW-1]}}, i_coord_x};
    assign ext_y = {{CCP_GUARD_BITS{i_coord_y[DW-1]}}, i_coord_y};

    // left half plane: turn by -90 deg when y > 0, else by +90 deg
    // (a negative x on the axis takes the -pi/2 branch)
    always_comb begin
        if (ext_x < 0) begin
            if (ext_y > 0) begin
                n_x0 = ext_y;
                n_y0 = -ext_x;
                n_z0 = HALF_PI;
            end else begin
                n_x0 = -ext_y;
                n_y0 = ext_x;
                n_z0 = -HALF_PI;
            end
        end else begin
            n_x0 = ext_x;
            n_y0 = ext_y;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
        r_y0 <= n_y0;
        r_z0 <= n_z0;
    end

    // ---------------- micro-rotation pipeline ----------------
    logic                 w_v [0:ITERATIONS];
    logic signed [IW-1:0] w_x [0:ITERATIONS];
    logic signed [IW-1:0] w_y [0:ITERATIONS];
    logic signed [AW-1:0] w_z [0:ITERATIONS];

    assign w_v[0] = r_v0;
    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        // each stage adds or takes off atan(2^-k), rounded at FB fraction bits
        ccp_iter #(
            .IW    (IW),
            .AW    (AW),
            .SHIFT (k),
            .ATAN  (AW'(to_fixed(atan_real(k), FB)))
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .o_valid (w_v[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    // ---------------- gain correction multiply ----------------
    logic                 r_v_m;
    logic [PW-1:0]        r_prod;
    logic signed [AW-1:0] r_z_m;
    logic [MW-1:0]        x_mag;

    // x only grows from a non-negative start, so the low bits are its magnitude
    assign x_mag = w_x[ITERATIONS][MW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_m <= 1'b0;
        end else begin
            r_v_m <= w_v[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(x_mag) * PW'(CCP_INV_GAIN);
        r_z_m  <= w_z[ITERATIONS];
    end

    // ---------------- rounding and saturation ----------------
    logic                 r_valid;
    logic signed [DW-1:0] r_radius, n_radius;
    logic signed [DW-1:0] r_angle, n_angle;
    logic [PW:0]          rounded;
    logic [RW-1:0]        rad_full;

    // round to nearest, ties up
    assign rounded  = {1'b0, r_prod} + ROUND_HALF;
    assign rad_full = rounded[PW:CCP_GAIN_SHIFT];

    always_comb begin
        if (rad_full > RAD_MAX) begin
            n_radius = ANG_MAX;
        end else begin
            n_radius = rad_full[DW-1:0];
        end
        // top two accumulator bits differ only on overflow
        if (r_z_m[AW-1] != r_z_m[AW-2]) begin
            n_angle = r_z_m[AW-1] ? ANG_MIN : ANG_MAX;
        end else begin
            n_angle = r_z_m[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_v_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radius <= n_radius;
        r_angle  <= n_angle;
    end

    assign o_valid  = r_valid;
    assign o_radius = r_radius;
    assign o_angle  = r_angle;

endmodule

// ===== hw/rtl/ccp_iter.sv =====
module ccp_iter
    import ccp_pkg::*;
#(
    parameter int IW = CCP_DATA_WIDTH + CCP_GUARD_BITS,
    parameter int AW = CCP_DATA_WIDTH + 1,
    parameter int SHIFT = 0,
    parameter logic signed [AW-1:0] ATAN = '0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [IW-1:0] i_x,
    input  logic signed [IW-1:0] i_y,
    input  logic signed [AW-1:0] i_z,
    output logic                 o_valid,
    output logic signed [IW-1:0] o_x,
    output logic signed [IW-1:0] o_y,
    output logic signed [AW-1:0] o_z
);

    logic                 r_valid;
    logic signed [IW-1:0] r_x, n_x;
    logic signed [IW-1:0] r_y, n_y;
    logic signed [AW-1:0] r_z, n_z;
    logic signed [IW-1:0] xs, ys;

    // arithmetic shifts round toward minus infinity
    assign xs = i_x >>> SHIFT;
    assign ys = i_y >>> SHIFT;

    // y of zero turns the same way as a negative y
    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== hw/rtl/ccp_checker.sv =====
module ccp_checker
    import ccp_pkg::*;
#(
    parameter int ITERATIONS = CCP_ITERATIONS,
    parameter int DATA_WIDTH = CCP_DATA_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [DATA_WIDTH-1:0] i_coord_x,
    input logic signed [DATA_WIDTH-1:0] i_coord_y,
    input logic                         o_valid,
    input logic signed [DATA_WIDTH-1:0] o_radius,
    input logic signed [DATA_WIDTH-1:0] o_angle
);

    localparam int LATENCY = ITERATIONS + CCP_FIXED_STAGES;

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted item did not come out after the pipeline latency");

    // a result only ever comes from an item taken the fixed latency earlier
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted item");

    // radius is a magnitude
    a_radius_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_radius[DATA_WIDTH-1])
        else $error("negative radius");

    // the origin has zero radius
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_coord_x == '0 && i_coord_y == '0)
            |-> ##LATENCY (o_valid && o_radius == '0))
        else $error("origin gave a nonzero radius");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind cordic_cartesian_to_polar ccp_checker #(
    .ITERATIONS (ITERATIONS),
    .DATA_WIDTH (DATA_WIDTH)
) u_ccp_checker (.*);
